// ===== sv/clsr_pkg.sv =====
// Shared constants, types and encodings for the combined LCG shuffle random source.
package clsr_pkg;

  localparam int unsigned TABLE_DEPTH = 32;
  localparam int unsigned WARMUP      = 8;

  localparam int unsigned VAL_W  = 31;
  localparam int unsigned MUL_W  = 16;
  localparam int unsigned PROD_W = VAL_W + MUL_W;
  localparam int unsigned FOLD_W = 8;

  localparam logic [VAL_W-1:0] MOD1       = 31'd2147483563;
  localparam logic [VAL_W-1:0] MOD2       = 31'd2147483399;
  localparam logic [VAL_W-1:0] MOD1_LESS1 = MOD1 - 31'd1;
  localparam logic [MUL_W-1:0] MUL1       = 16'd40014;
  localparam logic [MUL_W-1:0] MUL2       = 16'd40692;
  localparam logic [VAL_W-1:0] GEN1_RESET = 31'd1;
  localparam logic [VAL_W-1:0] GEN2_RESET = 31'd123456789;

  // 2^31 mod M for each modulus
  localparam logic [FOLD_W-1:0] FOLD1 = FOLD_W'((64'd1 << VAL_W) - 64'(MOD1));
  localparam logic [FOLD_W-1:0] FOLD2 = FOLD_W'((64'd1 << VAL_W) - 64'(MOD2));

  localparam logic [63:0] NDIV = 64'd1 + (64'(MOD1) - 64'd1) / 64'(TABLE_DEPTH);

  // selector / NDIV via reciprocal estimate plus one correction step
  localparam int unsigned RECIP_SH = 40;
  localparam int unsigned RECIP_W  = 17;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SH) / NDIV);
  localparam int unsigned EP_W = VAL_W + RECIP_W;

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned EST_W = IDX_W + 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + WARMUP);
  localparam logic [CNT_W-1:0] SEED_CNT = CNT_W'(TABLE_DEPTH + WARMUP - 1);

  localparam logic OP_DRAW   = 1'b0;
  localparam logic OP_RESEED = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED_MUL,
    ST_SEED_RED,
    ST_MUL,
    ST_RED,
    ST_IDX,
    ST_WR
  } state_t;

  typedef struct packed {
    logic load_seed;
    logic mul_first;
    logic mul_second;
    logic red_first;
    logic red_second;
    logic warm_step;
    logic read_tab;
    logic finish;
  } clsr_cmd_t;

  typedef struct packed {
    logic cnt_zero;
  } clsr_sts_t;

endpackage

// ===== sv/clsr_req_if.sv =====
// Request channel: opcode and seed magnitude.
interface clsr_req_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [clsr_pkg::VAL_W-1:0]  seed_magnitude;

  modport source (output valid, output opcode, output seed_magnitude, input ready);
  modport sink   (input valid, input opcode, input seed_magnitude, output ready);
endinterface

// ===== sv/clsr_rsp_if.sv =====
// Response channel: uniform deviate.
interface clsr_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [clsr_pkg::VAL_W-1:0]  deviate;

  modport source (output valid, output deviate, input ready);
  modport sink   (input valid, input deviate, output ready);
endinterface

// ===== sv/combined_lcg_shuffle_rng_unit.sv =====
// Draw: taken in ST_IDLE, then ST_RED, ST_IDX and ST_WR; ST_WR waits while a prior
//   deviate is unaccepted, and no new request is taken until ST_IDLE. Reseed: the warm-up
//   steps the shared first-generator multiply and reduce loop, then a normal draw.
// The deviate register frees the request side while a response waits.
// Reset (rst, synchronous) restores both generators and the selector and marks
//   every shuffle entry invalid, so unwritten entries read as zero.
module combined_lcg_shuffle_rng_unit (
  input logic       clk,
  input logic       rst,
  clsr_req_if.sink  req,
  clsr_rsp_if.source rsp
);
  import clsr_pkg::*;

  clsr_cmd_t cmd;
  clsr_sts_t sts;

  clsr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_opcode (req.opcode),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .cmd        (cmd),
    .sts        (sts)
  );

  clsr_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .sts     (sts),
    .seed    (req.seed_magnitude),
    .deviate (rsp.deviate)
  );

  a_dev_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.deviate != '0) && (rsp.deviate <= MOD1_LESS1))
    else $error("deviate out of range");

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while busy");

  a_draw_latency: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && (req.opcode == OP_DRAW) && !rsp.valid |-> ##4 rsp.valid)
    else $error("draw response late");

endmodule

// ===== sv/clsr_datapath.sv =====
// Generators, modular reduction, shuffle table memory and result register.
module clsr_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  clsr_pkg::clsr_cmd_t         cmd,
  output clsr_pkg::clsr_sts_t         sts,
  input  logic [clsr_pkg::VAL_W-1:0]  seed,
  output logic [clsr_pkg::VAL_W-1:0]  deviate
);
  import clsr_pkg::*;

  function automatic logic [VAL_W-1:0] fold_mod(input logic [PROD_W-1:0] p,
                                                input logic [FOLD_W-1:0] f,
                                                input logic [VAL_W-1:0]  m);
    logic [VAL_W:0] hi_x;
    logic [VAL_W:0] s;
    hi_x = (VAL_W+1)'(p[PROD_W-1:VAL_W]);
    s = {1'b0, p[VAL_W-1:0]} + hi_x * (VAL_W+1)'(f);
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[VAL_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] table_index(input logic [VAL_W-1:0] sel,
                                                   input logic [EP_W-1:0]  ep);
    logic [EST_W-1:0] est;
    logic [EST_W:0]   q;
    logic [63:0]      bound;
    est   = ep[RECIP_SH +: EST_W];
    bound = (64'(est) + 64'd1) * NDIV;
    if (64'(sel) >= bound) begin
      q = {1'b0, est} + (EST_W+1)'(1);
    end else begin
      q = {1'b0, est};
    end
    if (q >= (EST_W+1)'(TABLE_DEPTH)) begin
      q = (EST_W+1)'(TABLE_DEPTH - 1);
    end
    return q[IDX_W-1:0];
  endfunction

  logic [VAL_W-1:0]  first_gen;
  logic [VAL_W-1:0]  second_gen;
  logic [VAL_W-1:0]  selector;
  logic [CNT_W-1:0]  cnt;
  logic [PROD_W-1:0] prod1;
  logic [PROD_W-1:0] prod2;
  logic [EP_W-1:0]   est_prod;
  logic [IDX_W-1:0]  idx;
  logic [VAL_W-1:0]  rd_data;
  logic              rd_valid;

  logic [VAL_W-1:0]       mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] tab_valid;

  logic [VAL_W-1:0] first_red;
  logic [VAL_W-1:0] second_red;
  logic [VAL_W-1:0] seed_v;
  logic [IDX_W-1:0] rd_addr;
  logic [VAL_W-1:0] entry;
  logic [VAL_W-1:0] result;
  logic             warm_in_tab;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [VAL_W-1:0] wr_data;

  assign first_red   = fold_mod(prod1, FOLD1, MOD1);
  assign second_red  = fold_mod(prod2, FOLD2, MOD2);
  assign seed_v      = (seed == '0) ? VAL_W'(1) : seed;
  assign rd_addr     = table_index(selector, est_prod);
  assign entry       = rd_valid ? rd_data : '0;
  assign warm_in_tab = (32'(cnt) < TABLE_DEPTH);
  assign sts.cnt_zero = (cnt == '0);

  always_comb begin
    if (entry > second_gen) begin
      result = entry - second_gen;
    end else begin
      result = MOD1_LESS1 - (second_gen - entry);
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = first_gen;
    if (cmd.red_first && cmd.warm_step && warm_in_tab) begin
      wr_en   = 1'b1;
      wr_addr = cnt[IDX_W-1:0];
      wr_data = first_red;
    end else if (cmd.finish) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_gen  <= GEN1_RESET;
      second_gen <= GEN2_RESET;
      selector   <= '0;
      cnt        <= '0;
    end else begin
      if (cmd.load_seed) begin
        first_gen  <= seed_v;
        second_gen <= seed_v;
        cnt        <= SEED_CNT;
      end
      if (cmd.red_first) begin
        first_gen <= first_red;
      end
      if (cmd.red_second) begin
        second_gen <= second_red;
      end
      if (cmd.warm_step) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == '0) begin
          selector <= first_red;
        end
      end
      if (cmd.finish) begin
        selector <= result;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_first) begin
      prod1 <= PROD_W'(first_gen) * PROD_W'(MUL1);
    end
    if (cmd.mul_second) begin
      prod2    <= PROD_W'(second_gen) * PROD_W'(MUL2);
      est_prod <= EP_W'(selector) * EP_W'(RECIP);
    end
    if (cmd.read_tab) begin
      idx <= rd_addr;
    end
    if (cmd.finish) begin
      deviate <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.read_tab) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tab_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (wr_en) begin
        tab_valid[wr_addr] <= 1'b1;
      end
      if (cmd.read_tab) begin
        rd_valid <= tab_valid[rd_addr];
      end
    end
  end

endmodule

// ===== sv/clsr_ctrl.sv =====
// Sequencer for reseed warm-up and draw steps, plus response valid.
module clsr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  logic                 req_opcode,
  output logic                 req_ready,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output clsr_pkg::clsr_cmd_t  cmd,
  input  clsr_pkg::clsr_sts_t  sts
);
  import clsr_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid;
  logic   out_valid_next;

  assign rsp_valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    out_valid_next = out_valid && !rsp_ready;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          if (req_opcode == OP_RESEED) begin
            cmd.load_seed = 1'b1;
            state_next    = ST_SEED_MUL;
          end else begin
            cmd.mul_first  = 1'b1;
            cmd.mul_second = 1'b1;
            state_next     = ST_RED;
          end
        end
      end
      ST_SEED_MUL: begin
        cmd.mul_first = 1'b1;
        state_next    = ST_SEED_RED;
      end
      ST_SEED_RED: begin
        cmd.red_first = 1'b1;
        cmd.warm_step = 1'b1;
        state_next    = sts.cnt_zero ? ST_MUL : ST_SEED_MUL;
      end
      ST_MUL: begin
        cmd.mul_first  = 1'b1;
        cmd.mul_second = 1'b1;
        state_next     = ST_RED;
      end
      ST_RED: begin
        cmd.red_first  = 1'b1;
        cmd.red_second = 1'b1;
        state_next     = ST_IDX;
      end
      ST_IDX: begin
        cmd.read_tab = 1'b1;
        state_next   = ST_WR;
      end
      ST_WR: begin
        if (!out_valid || rsp_ready) begin
          cmd.finish     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sim/clsr_rng_checker.sv =====
// Checker: predicts each deviate from accepted requests and compares it with the responses.
module clsr_rng_checker (
  input  logic       clk,
  input  logic       rst,
  clsr_req_if        req,
  clsr_rsp_if        rsp,
  output int         errors,
  output int         pending,
  output int         draws,
  output int         reseeds,
  output int         checked
);
  import clsr_pkg::*;

  localparam logic [63:0] SLOT_SPAN = 64'd1 + (64'(MOD1) - 64'd1) / 64'(TABLE_DEPTH);
  localparam logic [VAL_W-1:0] DEV_TOP = MOD1 - 31'd1;

  logic [VAL_W-1:0] lcg_a;
  logic [VAL_W-1:0] lcg_b;
  logic [VAL_W-1:0] pick_sel;
  logic [VAL_W-1:0] shuffle [TABLE_DEPTH];
  logic [VAL_W-1:0] deviate_q [$];

  function automatic logic [VAL_W-1:0] step_a(logic [VAL_W-1:0] x);
    return VAL_W'((64'(MUL1) * 64'(x)) % 64'(MOD1));
  endfunction

  function automatic logic [VAL_W-1:0] step_b(logic [VAL_W-1:0] y);
    return VAL_W'((64'(MUL2) * 64'(y)) % 64'(MOD2));
  endfunction

  function automatic logic [VAL_W-1:0] next_deviate(logic op, logic [VAL_W-1:0] seed);
    logic [VAL_W-1:0] start;
    logic [VAL_W-1:0] held;
    logic [VAL_W-1:0] dev;
    int slot;
    if (op == OP_RESEED) begin
      start = (seed == '0) ? 31'd1 : seed;
      lcg_a = start;
      lcg_b = start;
      for (int n = TABLE_DEPTH + WARMUP - 1; n >= 0; n--) begin
        lcg_a = step_a(lcg_a);
        if (n < TABLE_DEPTH) shuffle[n] = lcg_a;
      end
      pick_sel = shuffle[0];
    end
    lcg_a = step_a(lcg_a);
    lcg_b = step_b(lcg_b);
    slot = int'(64'(pick_sel) / SLOT_SPAN);
    if (slot >= TABLE_DEPTH) slot = TABLE_DEPTH - 1;
    held = shuffle[slot];
    dev = (held > lcg_b) ? held - lcg_b : DEV_TOP - (lcg_b - held);
    shuffle[slot] = lcg_a;
    pick_sel = dev;
    return dev;
  endfunction

  always @(posedge clk) begin
    logic [VAL_W-1:0] want;
    if (rst) begin
      lcg_a = GEN1_RESET;
      lcg_b = GEN2_RESET;
      pick_sel = '0;
      foreach (shuffle[i]) shuffle[i] = '0;
      deviate_q.delete();
    end else begin
      if (req.valid && req.ready) begin
        deviate_q.push_back(next_deviate(req.opcode, req.seed_magnitude));
        if (req.opcode == OP_RESEED) reseeds++;
        else draws++;
      end
      if (rsp.valid && rsp.ready) begin
        if (deviate_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected deviate: expected none, got %0d", $time, rsp.deviate);
        end else begin
          want = deviate_q.pop_front();
          checked++;
          if (rsp.deviate !== want) begin
            errors++;
            $display("%0t: deviate mismatch: expected %0d, got %0d", $time, want,
                     rsp.deviate);
          end
        end
      end
    end
    pending = deviate_q.size();
  end

endmodule

// ===== sim/tb_combined_lcg_shuffle_rng_unit.sv =====
// Testbench top: clock, reset, request and response traffic, and the final verdict.
module tb_combined_lcg_shuffle_rng_unit;
  import clsr_pkg::*;

  localparam int RANDOM_REQUESTS = 850;
  localparam int CYCLE_LIMIT     = 600000;
  localparam int LONG_HOLD       = 300;
  localparam int SETTLE_CYCLES   = 120;
  localparam logic [VAL_W-1:0] SEED_ALL_ONES = 31'h7FFFFFFF;
  localparam logic [VAL_W-1:0] SEED_RANGE_TOP = 31'd2147483562;

  logic clk;
  logic rst;
  bit   calm;
  int   hold_asked;
  int   hold_served;
  int   hold_cycles;
  int   cycles;
  int   errors;
  int   pending;
  int   draws;
  int   reseeds;
  int   checked;

  clsr_req_if req_ch ();
  clsr_rsp_if rsp_ch ();

  combined_lcg_shuffle_rng_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  clsr_rng_checker chk (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .errors  (errors),
    .pending (pending),
    .draws   (draws),
    .reseeds (reseeds),
    .checked (checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timed out, %0d deviates outstanding", $time, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [VAL_W-1:0] pick_seed();
    int r;
    r = $urandom_range(0, 99);
    if (r < 62) return VAL_W'($urandom);
    if (r < 72) return VAL_W'($urandom_range(0, 1000));
    if (r < 82) return VAL_W'($urandom_range(2147483300, 2147483647));
    if (r < 86) begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return 31'd1;
        2: return MOD2;
        default: return MOD1;
      endcase
    end
    return VAL_W'($urandom_range(0, 2147483562));
  endfunction

  // entered and left at a falling edge; valid stays high between back-to-back requests
  task automatic send_request(input logic op, input logic [VAL_W-1:0] seed);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid          <= 1'b1;
    req_ch.opcode         <= op;
    req_ch.seed_magnitude <= seed;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  initial begin
    int hold;
    int r;
    hold = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        rsp_ch.ready <= 1'b0;
      end else if (hold_served != hold_asked) begin
        hold_served++;
        hold = LONG_HOLD - 1;
        hold_cycles += LONG_HOLD;
        rsp_ch.ready <= 1'b0;
      end else if (hold > 0) begin
        hold--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
        r = $urandom_range(0, 99);
        if (!calm) begin
          if (r < 70) hold = 0;
          else if (r < 90) hold = $urandom_range(1, 3);
          else if (r < 98) hold = $urandom_range(4, 12);
          else hold = $urandom_range(20, 50);
        end
      end
    end
  end

  initial begin
    logic op;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.opcode = OP_DRAW;
    req_ch.seed_magnitude = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // draws from the reset state, seed field ignored
    send_request(OP_DRAW, SEED_ALL_ONES);
    send_request(OP_DRAW, '0);
    send_request(OP_DRAW, VAL_W'($urandom));
    // zero seed behaves as one
    send_request(OP_RESEED, '0);
    send_request(OP_DRAW, SEED_ALL_ONES);
    send_request(OP_DRAW, '0);
    send_request(OP_RESEED, 31'd1);
    send_request(OP_DRAW, '0);
    send_request(OP_RESEED, SEED_RANGE_TOP);
    // second generator loaded with its modulus sticks at zero
    send_request(OP_RESEED, MOD2);
    send_request(OP_DRAW, '0);
    send_request(OP_DRAW, '0);
    // first generator loaded with its modulus sticks at zero
    send_request(OP_RESEED, MOD1);
    send_request(OP_DRAW, '0);
    send_request(OP_DRAW, '0);
    send_request(OP_RESEED, SEED_ALL_ONES);
    send_request(OP_DRAW, '0);
    send_request(OP_RESEED, 31'h55555555);
    send_request(OP_RESEED, 31'h2AAAAAAA);
    send_request(OP_DRAW, '0);

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i == 150) calm = 1'b1;
      if (i == 250) calm = 1'b0;
      if (i == 450 || i == 700) begin
        hold_asked++;
        calm = 1'b1;
      end
      if (i == 530 || i == 780) calm = 1'b0;
      op = ($urandom_range(0, 39) == 0) ? OP_RESEED : OP_DRAW;
      send_request(op, pick_seed());
    end
    req_ch.valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Sent %0d draws and %0d reseeds; compared %0d deviates.", draws, reseeds,
             checked);
    $display("Response side held off %0d cycles in long stretches to back up requests.",
             hold_cycles);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== combined_lcg_shuffle_rng_unit.f =====
sv/clsr_pkg.sv
sv/clsr_req_if.sv
sv/clsr_rsp_if.sv
sv/clsr_datapath.sv
sv/clsr_ctrl.sv
sv/combined_lcg_shuffle_rng_unit.sv
sim/clsr_rng_checker.sv
sim/tb_combined_lcg_shuffle_rng_unit.sv
